// ----- src/mfcu_pkg.sv -----
// types and constants shared by the compare unit
`default_nettype none
package mfcu_pkg;

  typedef enum logic [2:0] {
    OP_EQ = 3'd0,
    OP_NE = 3'd1,
    OP_LT = 3'd2,
    OP_GE = 3'd3,
    OP_LE = 3'd4,
    OP_GT = 3'd5
  } cmp_op_t;

  typedef enum logic [3:0] {
    DT_S8   = 4'd0,
    DT_U8   = 4'd1,
    DT_S16  = 4'd2,
    DT_U16  = 4'd3,
    DT_S32  = 4'd4,
    DT_U32  = 4'd5,
    DT_E4M3 = 4'd6,
    DT_E5M2 = 4'd7,
    DT_F16  = 4'd8,
    DT_F32  = 4'd9
  } data_type_t;

  typedef struct packed {
    logic [2:0]  compare_op;
    logic [3:0]  data_type;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } cmp_req_t;

  typedef struct packed {
    logic compare_true;
    logic type_error;
  } cmp_rsp_t;

  // ordering outcome after the magnitude stage
  typedef struct packed {
    logic [2:0] op;
    logic       err;
    logic       unord;
    logic       lt;
    logic       eq;
  } cmp_ord_t;

endpackage
`default_nettype wire

// ----- src/mfcu_order.sv -----
// first two stages: operand normalizing into 33-bit keys, then ordering
`default_nettype none
module mfcu_order (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                adv,
  input  wire mfcu_pkg::cmp_req_t  req,
  output mfcu_pkg::cmp_ord_t       ord
);
  import mfcu_pkg::*;

  logic [32:0] key_a, key_b, key_a_next, key_b_next;
  logic        unord, unord_next, err, err_next, is_signed, is_signed_next;
  logic [2:0]  op;
  logic        lt_next, eq_next;

  function automatic logic [32:0] fkey(input logic [31:0] v, input int unsigned tb);
    logic [32:0] mag;
    mag = {1'b0, v} & ((33'd1 << tb) - 33'd1);
    fkey = v[tb] ? (33'd0 - mag) : mag;
  endfunction

  always_comb begin
    key_a_next = '0;
    key_b_next = '0;
    unord_next = 1'b0;
    err_next = (req.compare_op > OP_GT);
    is_signed_next = 1'b1;
    unique case (req.data_type)
      DT_S8: begin
        key_a_next = {{25{req.operand_a[7]}}, req.operand_a[7:0]};
        key_b_next = {{25{req.operand_b[7]}}, req.operand_b[7:0]};
      end
      DT_U8: begin
        key_a_next = {25'd0, req.operand_a[7:0]};
        key_b_next = {25'd0, req.operand_b[7:0]};
      end
      DT_S16: begin
        key_a_next = {{17{req.operand_a[15]}}, req.operand_a[15:0]};
        key_b_next = {{17{req.operand_b[15]}}, req.operand_b[15:0]};
      end
      DT_U16: begin
        key_a_next = {17'd0, req.operand_a[15:0]};
        key_b_next = {17'd0, req.operand_b[15:0]};
      end
      DT_S32: begin
        key_a_next = {req.operand_a[31], req.operand_a};
        key_b_next = {req.operand_b[31], req.operand_b};
      end
      DT_U32: begin
        key_a_next = {1'b0, req.operand_a};
        key_b_next = {1'b0, req.operand_b};
      end
      DT_E4M3: begin
        key_a_next = fkey(req.operand_a, 7);
        key_b_next = fkey(req.operand_b, 7);
        unord_next = (req.operand_a[6:0] == 7'h7f) || (req.operand_b[6:0] == 7'h7f);
      end
      DT_E5M2: begin
        key_a_next = fkey(req.operand_a, 7);
        key_b_next = fkey(req.operand_b, 7);
        unord_next = (req.operand_a[6:2] == 5'h1f && req.operand_a[1:0] != 2'd0)
                  || (req.operand_b[6:2] == 5'h1f && req.operand_b[1:0] != 2'd0);
      end
      DT_F16: begin
        key_a_next = fkey(req.operand_a, 15);
        key_b_next = fkey(req.operand_b, 15);
        unord_next = (req.operand_a[14:10] == 5'h1f && req.operand_a[9:0] != 10'd0)
                  || (req.operand_b[14:10] == 5'h1f && req.operand_b[9:0] != 10'd0);
      end
      DT_F32: begin
        key_a_next = fkey(req.operand_a, 31);
        key_b_next = fkey(req.operand_b, 31);
        unord_next = (req.operand_a[30:23] == 8'hff && req.operand_a[22:0] != 23'd0)
                  || (req.operand_b[30:23] == 8'hff && req.operand_b[22:0] != 23'd0);
      end
      default: err_next = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      key_a <= key_a_next;
      key_b <= key_b_next;
      unord <= unord_next;
      err <= err_next;
      is_signed <= is_signed_next;
      op <= req.compare_op;
    end
  end

  // keys are 33-bit two's complement
  assign lt_next = is_signed && ($signed(key_a) < $signed(key_b));
  assign eq_next = (key_a == key_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      ord <= '0;
    end else if (adv) begin
      ord <= '{op: op, err: err, unord: unord, lt: lt_next, eq: eq_next};
    end
  end
endmodule
`default_nettype wire

// ----- src/multi_format_compare_unit_core.sv -----
// top level of the multi-format compare unit
// throughput: one request per cycle, stall freezes the whole pipe
// stages: key build, ordering, predicate into output register
// reset: rst synchronous, clears all valid bits
`default_nettype none
module multi_format_compare_unit_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mfcu_pkg::cmp_req_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mfcu_pkg::cmp_rsp_t      out_data
);
  import mfcu_pkg::*;

  logic [1:0] vld;
  logic       adv;
  cmp_ord_t   ord;
  logic       res_next;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  mfcu_order u_order (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .req (in_data),
    .ord (ord)
  );

  always_comb begin
    unique case (ord.op)
      OP_EQ:   res_next = ord.eq;
      OP_NE:   res_next = !ord.eq;
      OP_LT:   res_next = ord.lt;
      OP_GE:   res_next = !ord.lt;
      OP_LE:   res_next = ord.lt || ord.eq;
      OP_GT:   res_next = !ord.lt && !ord.eq;
      default: res_next = 1'b0;
    endcase
    if (ord.unord) res_next = (ord.op == OP_NE);
    if (ord.err) res_next = 1'b0;
  end

  // stage 1 and 2 valid bits, then output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld <= {vld[0], in_valid};
      out_valid <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= '{compare_true: res_next, type_error: ord.err};
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.type_error && out_data.compare_true))
    else $error("error with true result");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    adv && vld[1] |=> out_valid)
    else $error("request lost in pipe");
endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the multi-format compare unit
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import mfcu_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 650;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_OFF_START = 500;
  localparam logic [2:0] OP_BAD6 = 3'd6;
  localparam logic [2:0] OP_BAD7 = 3'd7;
  localparam logic [3:0] DT_BAD10 = 4'd10;
  localparam logic [3:0] DT_BAD15 = 4'd15;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  cmp_req_t in_data;
  logic out_valid;
  logic out_ready;
  cmp_rsp_t out_data;

  cmp_rsp_t expected_rsp_q[$];
  int unsigned mismatch_count = 0;
  int unsigned table_mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit quiet_phase;
  bit stimulus_done;

  multi_format_compare_unit_core i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] int_key(logic [31:0] v, int bits, bit sgn);
    logic [63:0] k;
    k = 64'(v & ((bits == 32) ? 32'hffff_ffff : ((32'd1 << bits) - 1)));
    if (sgn && v[bits-1]) begin
      k = k - (64'd1 << bits);
    end
    return k;
  endfunction

  function automatic bit decide(logic [2:0] op, int c, bit unord);
    if (unord) begin
      return op == OP_NE;
    end
    case (op)
      OP_EQ: return c == 0;
      OP_NE: return c != 0;
      OP_LT: return c < 0;
      OP_GE: return c >= 0;
      OP_LE: return c <= 0;
      default: return c > 0;
    endcase
  endfunction

  function automatic cmp_rsp_t predict_compare(cmp_req_t r);
    cmp_rsp_t rsp;
    int eb, mb, bits, c;
    bit sgn, is_fp, e4m3, unord;
    logic [63:0] ka, kb;
    logic [31:0] em, mm;
    rsp = '0;
    eb = 0; mb = 0; bits = 32; sgn = 0; is_fp = 0; e4m3 = 0; unord = 0;
    if (r.compare_op > OP_GT) begin
      rsp.type_error = 1'b1;
      return rsp;
    end
    case (r.data_type)
      DT_S8: begin bits = 8; sgn = 1; end
      DT_U8: bits = 8;
      DT_S16: begin bits = 16; sgn = 1; end
      DT_U16: bits = 16;
      DT_S32: sgn = 1;
      DT_U32: bits = 32;
      DT_E4M3: begin is_fp = 1; e4m3 = 1; eb = 4; mb = 3; end
      DT_E5M2: begin is_fp = 1; eb = 5; mb = 2; end
      DT_F16: begin is_fp = 1; eb = 5; mb = 10; end
      DT_F32: begin is_fp = 1; eb = 8; mb = 23; end
      default: begin
        rsp.type_error = 1'b1;
        return rsp;
      end
    endcase
    if (is_fp) begin
      em = (32'd1 << eb) - 1;
      mm = (32'd1 << mb) - 1;
      for (int k = 0; k < 2; k++) begin
        logic [31:0] v;
        v = k ? r.operand_b : r.operand_a;
        if (((v >> mb) & em) == em) begin
          if (e4m3 ? ((v & mm) == mm) : ((v & mm) != 0)) unord = 1;
        end
      end
      ka = int_key(r.operand_a, eb + mb, 0);
      kb = int_key(r.operand_b, eb + mb, 0);
      if (r.operand_a[eb+mb]) ka = -ka;
      if (r.operand_b[eb+mb]) kb = -kb;
      sgn = 1;
    end else begin
      ka = int_key(r.operand_a, bits, sgn);
      kb = int_key(r.operand_b, bits, sgn);
      sgn = 1;
    end
    c = ($signed(ka) < $signed(kb)) ? -1 : (($signed(ka) > $signed(kb)) ? 1 : 0);
    rsp.compare_true = decide(r.compare_op, c, unord);
    return rsp;
  endfunction

  task automatic send_request(cmp_req_t r);
    while (!quiet_phase && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_rsp_q.push_back(predict_compare(r));
  endtask

  function automatic cmp_req_t make_req(logic [2:0] op, logic [3:0] dt,
                                        logic [31:0] a, logic [31:0] b);
    cmp_req_t r;
    r.compare_op = op;
    r.data_type = dt;
    r.operand_a = a;
    r.operand_b = b;
    return r;
  endfunction

  function automatic logic [31:0] random_operand(logic [3:0] dt);
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(7))
      0: v = 32'h0;
      1: v = 32'hffff_ffff;
      2: begin
        case (dt)
          DT_E4M3, DT_E5M2: v[7:0] = 8'h80;
          DT_F16: v[15:0] = 16'h8000;
          DT_F32: v = 32'h8000_0000;
          default: v = 32'h8000_0000;
        endcase
      end
      3: begin
        case (dt)
          DT_E4M3: v[6:0] = 7'h7f;
          DT_E5M2: v[6:2] = 5'h1f;
          DT_F16: v[14:10] = 5'h1f;
          DT_F32: v[30:23] = 8'hff;
          default: v[7:0] = 8'h7f;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  typedef struct {
    cmp_req_t req;
    bit has_rsp;
    cmp_rsp_t rsp;
  } stim_row_t;

  stim_row_t stim_table[] = '{
    '{make_req(OP_LT, DT_S8, 32'h0000_0080, 32'h0000_007f), 1, '{1'b1, 1'b0}},
    '{make_req(OP_LT, DT_U8, 32'h0000_0080, 32'h0000_007f), 1, '{1'b0, 1'b0}},
    '{make_req(OP_EQ, DT_S8, 32'hffff_ff05, 32'h0000_0005), 1, '{1'b1, 1'b0}},
    '{make_req(OP_GT, DT_S16, 32'h0000_7fff, 32'h0000_8000), 1, '{1'b1, 1'b0}},
    '{make_req(OP_GE, DT_U16, 32'h0000_ffff, 32'h0000_ffff), 1, '{1'b1, 1'b0}},
    '{make_req(OP_LE, DT_S32, 32'h8000_0000, 32'h7fff_ffff), 1, '{1'b1, 1'b0}},
    '{make_req(OP_NE, DT_U32, 32'hffff_ffff, 32'h0000_0000), 1, '{1'b1, 1'b0}},
    '{make_req(OP_EQ, DT_F32, 32'h8000_0000, 32'h0000_0000), 1, '{1'b1, 1'b0}},
    '{make_req(OP_NE, DT_F32, 32'h7fc0_0000, 32'h7fc0_0000), 1, '{1'b1, 1'b0}},
    '{make_req(OP_EQ, DT_F32, 32'h7fc0_0000, 32'h7fc0_0000), 1, '{1'b0, 1'b0}},
    '{make_req(OP_LT, DT_F32, 32'hff80_0000, 32'h7f80_0000), 1, '{1'b1, 1'b0}},
    '{make_req(OP_GE, DT_F16, 32'h0000_7c01, 32'h0000_0000), 1, '{1'b0, 1'b0}},
    '{make_req(OP_LT, DT_F16, 32'h0000_8001, 32'h0000_0001), 1, '{1'b1, 1'b0}},
    '{make_req(OP_GT, DT_E5M2, 32'h0000_007c, 32'h0000_007b), 1, '{1'b1, 1'b0}},
    '{make_req(OP_NE, DT_E5M2, 32'h0000_007d, 32'h0000_0000), 1, '{1'b1, 1'b0}},
    '{make_req(OP_GT, DT_E4M3, 32'h0000_007e, 32'h0000_0077), 1, '{1'b1, 1'b0}},
    '{make_req(OP_LE, DT_E4M3, 32'h0000_007f, 32'h0000_007f), 1, '{1'b0, 1'b0}},
    '{make_req(OP_EQ, DT_E4M3, 32'h0000_0080, 32'hffff_ff00), 1, '{1'b1, 1'b0}},
    '{make_req(OP_BAD6, DT_S8, 32'h0, 32'h0), 1, '{1'b0, 1'b1}},
    '{make_req(OP_BAD7, DT_F32, 32'h0, 32'h0), 1, '{1'b0, 1'b1}},
    '{make_req(OP_EQ, DT_BAD10, 32'h0, 32'h0), 1, '{1'b0, 1'b1}},
    '{make_req(OP_NE, DT_BAD15, 32'h1, 32'h2), 1, '{1'b0, 1'b1}}
  };

  initial begin
    cmp_req_t r;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    stimulus_done = 0;
    quiet_phase = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (stim_table[i]) begin
      if (stim_table[i].has_rsp &&
          predict_compare(stim_table[i].req) != stim_table[i].rsp) begin
        table_mismatch_count++;
        $display("table row %0d disagrees with predictor", i);
      end
      send_request(stim_table[i].req);
    end
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      quiet_phase = (n >= 200 && n < 300);
      r.compare_op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                                : 3'($urandom_range(5));
      r.data_type = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
                                               : 4'($urandom_range(9));
      r.operand_a = random_operand(r.data_type);
      r.operand_b = ($urandom_range(5) == 0) ? r.operand_a : random_operand(r.data_type);
      if ($urandom_range(7) == 0) r.operand_b = r.operand_a ^ (32'd1 << $urandom_range(31));
      send_request(r);
    end
    in_valid <= 1'b0;
    stimulus_done = 1;
  end

  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (cycle_count == HOLD_OFF_START) begin
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
      end
      out_ready <= quiet_phase || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin
    cmp_rsp_t exp_rsp;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && out_ready) begin
      if (expected_rsp_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", out_data);
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        if (out_data.compare_true !== exp_rsp.compare_true ||
            out_data.type_error !== exp_rsp.type_error) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected true=%b err=%b, got true=%b err=%b",
                     exp_rsp.compare_true, exp_rsp.type_error,
                     out_data.compare_true, out_data.type_error);
        end
      end
    end
  end

  initial begin
    wait (stimulus_done);
    while (expected_rsp_q.size() != 0 && cycle_count < CYCLE_LIMIT) @(posedge clk);
    repeat (10) @(posedge clk);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
    end else if (mismatch_count == 0 && table_mismatch_count == 0 &&
                 expected_rsp_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT + 100);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
`default_nettype wire

// ----- multi_format_compare_unit_core.f -----
src/mfcu_pkg.sv
src/mfcu_order.sv
src/multi_format_compare_unit_core.sv
tb/sv/testbench.sv
